// ===== rtl/core/polyev_pkg.sv =====
// shared types and constants for the polynomial evaluator
package polyev_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = 3;
    localparam int IDX_W  = 3;

    localparam int MAX_TERMS_DEF = 5;
    localparam int FRAC_BITS_DEF = 16;

    // evaluation modes
    localparam logic MODE_COEF = 1'b0;
    localparam logic MODE_ROOT = 1'b1;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_EVAL_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_TERM_COUNT = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROOT_GAIN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_TERM_BASE  = 3'd3;

    // reset values
    localparam logic              EVAL_MODE_RST  = MODE_COEF;
    localparam logic [CNT_W-1:0]  TERM_COUNT_RST = 3'd1;
    localparam logic [DATA_W-1:0] ROOT_GAIN_RST  = 32'h0001_0000;

    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // one item travelling down the cell row
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] acc;
        logic              ovf;
        logic              bad;
    } t_item;

endpackage

// ===== rtl/core/polyev_cell.sv =====
// one evaluation step: operand prep, multiply, round and saturate, then add in coefficient mode
module polyev_cell #(
    parameter int FRAC_BITS = polyev_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_mode,
    input  logic                          i_active,
    input  logic [polyev_pkg::DATA_W-1:0] i_term,
    input  logic                          i_valid,
    input  polyev_pkg::t_item             i_item,
    output logic                          o_ready,
    output logic                          o_valid,
    output polyev_pkg::t_item             o_item,
    input  logic                          i_ready
);

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;
    localparam logic signed [63:0] RND   = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    logic r_va, r_vb, r_vc;
    logic w_acc_a, w_acc_b, w_acc_c;

    polyev_pkg::t_item n_a_item, r_a_item, r_b_item, n_c_item, r_c_item;
    logic [polyev_pkg::DATA_W-1:0] n_a_op, r_a_op, n_c_m, r_c_m;
    logic signed [63:0] r_b_prod;

    logic [32:0] w_diff;
    logic        w_diff_ovf;
    logic signed [31:0] w_op_s, w_acc_s;
    logic signed [63:0] w_prod, w_q;
    logic        w_root;

    logic [32:0] w_sum;
    logic        w_sum_ovf;
    logic [31:0] w_sum_sat;

    assign w_acc_c = !r_vc || i_ready;
    assign w_acc_b = !r_vb || w_acc_c;
    assign w_acc_a = !r_va || w_acc_b;
    assign o_ready = w_acc_a;
    assign o_valid = r_vc;

    assign w_root = (i_mode == polyev_pkg::MODE_ROOT) && i_active;

    // stage a: x - root with saturation in an active root-mode cell, x itself otherwise
    assign w_diff     = {i_item.x[31], i_item.x} - {i_term[31], i_term};
    assign w_diff_ovf = w_diff[32] != w_diff[31];

    always_comb begin
        n_a_item = i_item;
        n_a_op   = i_item.x;
        if (w_root) begin
            if (w_diff_ovf) begin
                n_a_op = w_diff[32] ? polyev_pkg::SAT_MIN : polyev_pkg::SAT_MAX;
            end else begin
                n_a_op = w_diff[31:0];
            end
            n_a_item.ovf = i_item.ovf | w_diff_ovf;
        end
    end

    // stage b: full product
    assign w_op_s  = r_a_op;
    assign w_acc_s = r_a_item.acc;
    assign w_prod  = w_op_s * w_acc_s;

    // stage c: scale with rounding toward zero, then saturate
    assign w_q = (r_b_prod + (r_b_prod[63] ? RND : 64'sd0)) >>> FRAC_BITS;

    always_comb begin
        n_c_item = r_b_item;
        if (w_q > Q_MAX) begin
            n_c_m        = polyev_pkg::SAT_MAX;
            n_c_item.ovf = r_b_item.ovf | i_active;
        end else if (w_q < Q_MIN) begin
            n_c_m        = polyev_pkg::SAT_MIN;
            n_c_item.ovf = r_b_item.ovf | i_active;
        end else begin
            n_c_m = w_q[31:0];
        end
    end

    // output: coefficient add in horner form in coefficient mode, scaled product alone in root mode
    assign w_sum     = {i_term[31], i_term} + {r_c_m[31], r_c_m};
    assign w_sum_ovf = w_sum[32] != w_sum[31];
    assign w_sum_sat = w_sum_ovf ? (w_sum[32] ? polyev_pkg::SAT_MIN : polyev_pkg::SAT_MAX)
                                 : w_sum[31:0];

    always_comb begin
        o_item = r_c_item;
        if (i_active) begin
            if (i_mode == polyev_pkg::MODE_COEF) begin
                o_item.acc = w_sum_sat;
                o_item.ovf = r_c_item.ovf | w_sum_ovf;
            end else begin
                o_item.acc = r_c_m;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (w_acc_a) begin
                r_va <= i_valid;
            end
            if (w_acc_b) begin
                r_vb <= r_va;
            end
            if (w_acc_c) begin
                r_vc <= r_vb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_a) begin
            r_a_item <= n_a_item;
            r_a_op   <= n_a_op;
        end
        if (w_acc_b) begin
            r_b_item <= r_a_item;
            r_b_prod <= w_prod;
        end
        if (w_acc_c) begin
            r_c_item <= n_c_item;
            r_c_m    <= n_c_m;
        end
    end

endmodule

// ===== rtl/core/polynomial_evaluator.sv =====
// throughput: one x sample per cycle while o_stall is low; a row of MAX_TERMS pipelined cells, each with
//   one 32x32 multiplier, handles one horner or root step per item
// reset: synchronous active low; empties the pipeline and output register and
//   returns the configuration registers to their reset values
// top level of the polynomial evaluator: configuration, cell row and output register
module polynomial_evaluator #(
    parameter int MAX_TERMS = polyev_pkg::MAX_TERMS_DEF,
    parameter int FRAC_BITS = polyev_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [polyev_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [polyev_pkg::DATA_W-1:0] i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [31:0]            i_x_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [31:0]            o_poly_value,
    output logic                          o_overflowed,
    output logic                          o_bad_length
);

    logic                               r_eval_mode;
    logic [polyev_pkg::CNT_W-1:0]       r_term_count;
    logic [polyev_pkg::DATA_W-1:0]      r_root_gain;
    logic [polyev_pkg::DATA_W-1:0]      r_term [MAX_TERMS];

    logic [polyev_pkg::CNT_W-1:0]       w_n;
    polyev_pkg::t_item                  w_init;
    polyev_pkg::t_item                  w_item  [MAX_TERMS+1];
    logic                               w_valid [MAX_TERMS+1];
    logic                               w_ready [MAX_TERMS+1];

    logic                               w_acc_out;
    logic                               r_out_valid;
    polyev_pkg::t_item                  r_out_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eval_mode  <= polyev_pkg::EVAL_MODE_RST;
            r_term_count <= polyev_pkg::TERM_COUNT_RST;
            r_root_gain  <= polyev_pkg::ROOT_GAIN_RST;
            for (int k = 0; k < MAX_TERMS; k++) begin
                r_term[k] <= '0;
            end
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == polyev_pkg::REG_EVAL_MODE) begin
                r_eval_mode <= i_cfg_wdata[0];
            end
            if (i_cfg_index == polyev_pkg::REG_TERM_COUNT) begin
                r_term_count <= i_cfg_wdata[polyev_pkg::CNT_W-1:0];
            end
            if (i_cfg_index == polyev_pkg::REG_ROOT_GAIN) begin
                r_root_gain <= i_cfg_wdata;
            end
            for (int k = 0; k < MAX_TERMS; k++) begin
                if (i_cfg_index == polyev_pkg::REG_TERM_BASE + polyev_pkg::IDX_W'(k)) begin
                    r_term[k] <= i_cfg_wdata;
                end
            end
        end
    end

    // term count clamped to the row length
    assign w_n = (r_term_count > polyev_pkg::CNT_W'(MAX_TERMS))
               ? polyev_pkg::CNT_W'(MAX_TERMS) : r_term_count;

    // starting accumulator: leading coefficient or root gain; a zero count in coefficient mode flags bad length
    always_comb begin
        w_init     = '0;
        w_init.x   = i_x_value;
        if (r_eval_mode == polyev_pkg::MODE_ROOT) begin
            w_init.acc = r_root_gain;
        end else if (w_n == '0) begin
            w_init.bad = 1'b1;
        end else begin
            for (int k = 0; k < MAX_TERMS; k++) begin
                if (w_n == polyev_pkg::CNT_W'(k + 1)) begin
                    w_init.acc = r_term[k];
                end
            end
        end
    end

    assign w_item[0]  = w_init;
    assign w_valid[0] = i_valid;
    assign o_stall    = !w_ready[0];

    // cell k handles term index MAX_TERMS-1-k, highest first
    for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
        localparam int TIDX = MAX_TERMS - 1 - k;
        logic w_active;

        assign w_active = (r_eval_mode == polyev_pkg::MODE_ROOT)
                        ? ({1'b0, w_n} >= 4'(TIDX + 1))
                        : ({1'b0, w_n} >= 4'(TIDX + 2));

        polyev_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_mode   (r_eval_mode),
            .i_active (w_active),
            .i_term   (r_term[TIDX]),
            .i_valid  (w_valid[k]),
            .i_item   (w_item[k]),
            .o_ready  (w_ready[k]),
            .o_valid  (w_valid[k+1]),
            .o_item   (w_item[k+1]),
            .i_ready  (w_ready[k+1])
        );
    end

    // output register
    assign w_acc_out          = !r_out_valid || !i_stall;
    assign w_ready[MAX_TERMS] = w_acc_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc_out) begin
            r_out_valid <= w_valid[MAX_TERMS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc_out) begin
            r_out_item <= w_item[MAX_TERMS];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_poly_value = r_out_item.acc;
    assign o_overflowed = r_out_item.ovf;
    assign o_bad_length = r_out_item.bad;

    a_bad_len_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_length |-> (o_poly_value == '0) && !o_overflowed)
        else $error("bad length result carries a value or overflow");

    a_empty_no_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while output register is empty");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

// ===== bench/polynomial_evaluator_test.sv =====
// self-checking testbench for polynomial_evaluator: directed table plus random phases
`timescale 1ns / 100ps

module polynomial_evaluator_test;

    import polyev_pkg::*;

    localparam int          LATENCY     = 3 * MAX_TERMS_DEF + 1;
    localparam int          HOLD_CYCLES = 80;
    localparam int          HOLD_PHASE  = 5;
    localparam int          HOLD_RUN    = 120;
    localparam int          RANDOM_ITEMS = 930;
    localparam int          N_DIRECTED  = 24;
    localparam int unsigned X_SPAN      = 32'h0004_0000;
    localparam int unsigned TERM_SPAN   = 32'h0010_0000;
    localparam int unsigned GAIN_SPAN   = 32'h0004_0000;

    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_NEG_ONE = 32'hFFFF_0000;
    localparam longint      Q_MAX_L   = 64'sd2147483647;
    localparam longint      Q_MIN_L   = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] value;
        logic        ovf;
        logic        bad;
    } poly_result_t;

    typedef struct packed {
        logic        mode;
        logic [2:0]  count;
        logic [31:0] gain;
        logic [31:0] t0;
        logic [31:0] t1;
        logic [31:0] t2;
        logic [31:0] t3;
        logic [31:0] t4;
        logic [31:0] x;
        logic        chk;
        logic [31:0] e_val;
        logic        e_ovf;
        logic        e_bad;
    } poly_vector_t;

    // mode, count, gain, t0..t4, x, typed-in check, value, overflow, bad length
    localparam poly_vector_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{MODE_COEF, 3'd1, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          SAT_MAX, 1'b1, 32'h0, 1'b0, 1'b0},
        '{MODE_COEF, 3'd1, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          SAT_MIN, 1'b1, 32'h0, 1'b0, 1'b0},
        '{MODE_COEF, 3'd0, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h1234_5678, 1'b1, 32'h0, 1'b0, 1'b1},
        '{MODE_COEF, 3'd0, Q_ONE, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          SAT_MIN, 1'b1, 32'h0, 1'b0, 1'b1},
        '{MODE_ROOT, 3'd0, SAT_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0BAD_F00D, 1'b1, SAT_MAX, 1'b0, 1'b0},
        '{MODE_ROOT, 3'd0, SAT_MIN, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          SAT_MAX, 1'b1, SAT_MIN, 1'b0, 1'b0},
        '{MODE_COEF, 3'd1, Q_ONE, SAT_MAX, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0003_0000, 1'b1, SAT_MAX, 1'b0, 1'b0},
        '{MODE_COEF, 3'd1, Q_ONE, SAT_MIN, 32'h0, 32'h0, 32'h0, 32'h0,
          32'h0, 1'b1, SAT_MIN, 1'b0, 1'b0},
        // product lands exactly on the most negative value, no saturation
        '{MODE_COEF, 3'd2, Q_ONE, 32'h0, Q_ONE, 32'h0, 32'h0, 32'h0,
          SAT_MIN, 1'b1, SAT_MIN, 1'b0, 1'b0},
        '{MODE_COEF, 3'd2, Q_ONE, 32'h0, Q_ONE, 32'h0, 32'h0, 32'h0,
          SAT_MAX, 1'b1, SAT_MAX, 1'b0, 1'b0},
        '{MODE_COEF, 3'd2, Q_ONE, 32'h0, SAT_MAX, 32'h0, 32'h0, 32'h0,
          SAT_MAX, 1'b1, SAT_MAX, 1'b1, 1'b0},
        '{MODE_COEF, 3'd2, Q_ONE, 32'h0, SAT_MIN, 32'h0, 32'h0, 32'h0,
          SAT_MAX, 1'b1, SAT_MIN, 1'b1, 1'b0},
        // sum saturates while the product does not
        '{MODE_COEF, 3'd2, Q_ONE, SAT_MAX, Q_ONE, 32'h0, 32'h0, 32'h0,
          Q_ONE, 1'b1, SAT_MAX, 1'b1, 1'b0},
        // tiny negative product truncates toward zero
        '{MODE_COEF, 3'd2, Q_ONE, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0,
          32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0, 1'b0},
        '{MODE_COEF, 3'd2, Q_ONE, 32'h0, 32'h3, 32'h0, 32'h0, 32'h0,
          Q_NEG_ONE, 1'b1, 32'hFFFF_FFFD, 1'b0, 1'b0},
        '{MODE_COEF, 3'd5, Q_ONE, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
          Q_ONE, 32'hFFFF_8000, 32'hFFFE_8000, 1'b0, 32'h0, 1'b0, 1'b0},
        // counts above the cell row size clamp to full length
        '{MODE_COEF, 3'd7, Q_ONE, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
          Q_ONE, 32'hFFFF_8000, Q_ONE, 1'b0, 32'h0, 1'b0, 1'b0},
        '{MODE_COEF, 3'd6, Q_ONE, 32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000,
          Q_ONE, 32'hFFFF_8000, 32'h0002_8000, 1'b0, 32'h0, 1'b0, 1'b0},
        // difference saturates, then unit gain keeps it
        '{MODE_ROOT, 3'd1, Q_ONE, SAT_MAX, 32'h0, 32'h0, 32'h0, 32'h0,
          SAT_MIN, 1'b1, SAT_MIN, 1'b1, 1'b0},
        '{MODE_ROOT, 3'd2, Q_ONE, 32'h0002_0000, Q_NEG_ONE, 32'h0, 32'h0, 32'h0,
          32'h0002_0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{MODE_ROOT, 3'd5, 32'h0000_8000, Q_ONE, Q_NEG_ONE, 32'h0002_0000,
          32'hFFFE_0000, 32'h0000_8000, 32'h0003_0000, 1'b0, 32'h0, 1'b0, 1'b0},
        '{MODE_ROOT, 3'd7, 32'h0000_8000, Q_ONE, Q_NEG_ONE, 32'h0002_0000,
          32'hFFFE_0000, 32'h0000_8000, 32'hFFFD_4000, 1'b0, 32'h0, 1'b0, 1'b0},
        '{MODE_ROOT, 3'd3, SAT_MAX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
          SAT_MAX, 1'b0, 32'h0, 1'b0, 1'b0},
        '{MODE_COEF, 3'd3, Q_ONE, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h8000_0001,
          32'h0, 32'h0, 32'h0000_FFFF, 1'b0, 32'h0, 1'b0, 1'b0}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [IDX_W-1:0]  i_cfg_index = '0;
    logic [DATA_W-1:0] i_cfg_wdata = '0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    logic signed [31:0] i_x_value = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    logic signed [31:0] o_poly_value;
    logic        o_overflowed;
    logic        o_bad_length;

    // configuration as the block should hold it
    logic              cfg_mode  = EVAL_MODE_RST;
    logic [2:0]        cfg_count = TERM_COUNT_RST;
    logic signed [31:0] cfg_gain = ROOT_GAIN_RST;
    logic signed [31:0] cfg_terms [MAX_TERMS_DEF] = '{default: '0};

    poly_result_t pending_values [$];
    poly_result_t oldest;
    int           x_accepted     = 0;
    int           mismatch_count = 0;
    int           hold_left      = 0;
    logic         hold_done      = 1'b0;
    logic         hold_go        = 1'b0;

    polynomial_evaluator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_x_value    (i_x_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_poly_value (o_poly_value),
        .o_overflowed (o_overflowed),
        .o_bad_length (o_bad_length)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic longint clamp32(input longint v, inout logic ovf);
        if (v > Q_MAX_L) begin
            ovf = 1'b1;
            return Q_MAX_L;
        end
        if (v < Q_MIN_L) begin
            ovf = 1'b1;
            return Q_MIN_L;
        end
        return v;
    endfunction

    // fixed point product, truncated toward zero, then saturated
    function automatic longint fixed_mul(input longint a, input longint b, inout logic ovf);
        longint p;
        longint mag;
        p   = a * b;
        mag = (p < 0) ? -p : p;
        mag = mag >> FRAC_BITS_DEF;
        if (p < 0) begin
            if (mag > -Q_MIN_L) begin
                ovf = 1'b1;
                return Q_MIN_L;
            end
            return -mag;
        end
        if (mag > Q_MAX_L) begin
            ovf = 1'b1;
            return Q_MAX_L;
        end
        return mag;
    endfunction

    function automatic poly_result_t poly_at(input logic signed [31:0] x);
        poly_result_t r;
        longint       acc;
        longint       prod;
        longint       d;
        logic         ovf;
        int           n;
        ovf   = 1'b0;
        r.bad = 1'b0;
        n = (cfg_count > MAX_TERMS_DEF) ? MAX_TERMS_DEF : int'(cfg_count);
        if (cfg_mode == MODE_COEF) begin
            if (n == 0) begin
                r.bad = 1'b1;
                acc   = 0;
            end else begin
                acc = longint'(cfg_terms[n-1]);
                for (int i = n - 2; i >= 0; i--) begin
                    prod = fixed_mul(longint'(x), acc, ovf);
                    acc  = clamp32(longint'(cfg_terms[i]) + prod, ovf);
                end
            end
        end else begin
            // innermost root first
            acc = longint'(cfg_gain);
            for (int i = n - 1; i >= 0; i--) begin
                d   = clamp32(longint'(x) - longint'(cfg_terms[i]), ovf);
                acc = fixed_mul(d, acc, ovf);
            end
        end
        r.value = acc[31:0];
        r.ovf   = ovf;
        return r;
    endfunction

    function automatic logic calm_stretch();
        return x_accepted >= 450 && x_accepted < 600;
    endfunction

    // mostly moderate values so results do not always saturate
    function automatic logic [31:0] pick_value(input int unsigned half_span);
        case ($urandom_range(19))
            0:       return SAT_MAX;
            1:       return SAT_MIN;
            2:       return 32'h0;
            3:       return Q_ONE;
            4:       return Q_NEG_ONE;
            5, 6, 7: return $urandom;
            default: return 32'($urandom_range(2 * half_span) - half_span);
        endcase
    endfunction

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    // waits for the block to empty, then writes what differs (or everything)
    task automatic load_setup(input logic mode, input logic [2:0] count,
                              input logic [31:0] gain, input logic [4:0][31:0] vals,
                              input logic rewrite_all);
        logic changed;
        changed = rewrite_all || mode != cfg_mode || count != cfg_count || gain != cfg_gain;
        for (int i = 0; i < MAX_TERMS_DEF; i++)
            if (vals[i] != cfg_terms[i]) changed = 1'b1;
        if (changed) begin
            i_valid <= 1'b0;
            while (pending_values.size() != 0) @(posedge i_clk);
            if (rewrite_all || mode != cfg_mode) write_reg(REG_EVAL_MODE, 32'(mode));
            if (rewrite_all || count != cfg_count) write_reg(REG_TERM_COUNT, 32'(count));
            if (rewrite_all || gain != cfg_gain) write_reg(REG_ROOT_GAIN, gain);
            for (int i = 0; i < MAX_TERMS_DEF; i++)
                if (rewrite_all || vals[i] != cfg_terms[i])
                    write_reg(REG_TERM_BASE + IDX_W'(i), vals[i]);
            i_cfg_wr_en <= 1'b0;
            cfg_mode  = mode;
            cfg_count = count;
            cfg_gain  = gain;
            for (int i = 0; i < MAX_TERMS_DEF; i++) cfg_terms[i] = vals[i];
        end
    endtask

    task automatic send_x(input logic [31:0] x, input poly_result_t want);
        if (!calm_stretch() && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_x_value <= x;
        do @(posedge i_clk); while (o_stall);
        pending_values.push_back(want);
        x_accepted++;
    endtask

    // receiver side: random stalls, one long hold-off, one calm stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_done && hold_go) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= !calm_stretch() && ($urandom_range(99) < 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_values.size() == 0) begin
                $error("unexpected transfer: poly_value %h", o_poly_value);
                mismatch_count++;
            end else begin
                oldest = pending_values.pop_front();
                if (o_poly_value !== oldest.value) begin
                    $error("poly_value: expected %h, actual %h", oldest.value, o_poly_value);
                    mismatch_count++;
                end
                if (o_overflowed !== oldest.ovf) begin
                    $error("overflowed: expected %b, actual %b", oldest.ovf, o_overflowed);
                    mismatch_count++;
                end
                if (o_bad_length !== oldest.bad) begin
                    $error("bad_length: expected %b, actual %b", oldest.bad, o_bad_length);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        poly_vector_t      row;
        poly_result_t      want;
        logic [4:0][31:0]  vals;
        logic [31:0]       x;
        int                phase;
        int                random_sent;
        int                run_len;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++) begin
            row = DIRECTED_ROWS[k];
            load_setup(row.mode, row.count, row.gain,
                       {row.t4, row.t3, row.t2, row.t1, row.t0}, 1'b0);
            if (row.chk) begin
                want.value = row.e_val;
                want.ovf   = row.e_ovf;
                want.bad   = row.e_bad;
            end else begin
                want = poly_at(row.x);
            end
            send_x(row.x, want);
        end

        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case (phase)
                0: load_setup(MODE_COEF, 3'd5, Q_ONE, {5{SAT_MAX}}, 1'b1);
                1: load_setup(MODE_ROOT, 3'd7, SAT_MIN, {5{SAT_MIN}}, 1'b1);
                2: load_setup(MODE_ROOT, 3'd5, SAT_MAX, '0, 1'b1);
                default: begin
                    for (int i = 0; i < MAX_TERMS_DEF; i++) vals[i] = pick_value(TERM_SPAN);
                    load_setup(1'($urandom_range(1)), 3'($urandom_range(7)),
                               pick_value(GAIN_SPAN), vals, 1'b1);
                end
            endcase
            run_len = $urandom_range(15, 60);
            if (phase == HOLD_PHASE) begin
                // long run behind the receiver hold-off so the block fills and stalls
                run_len = HOLD_RUN;
                hold_go = 1'b1;
            end
            repeat (run_len) begin
                x = pick_value(X_SPAN);
                send_x(x, poly_at(x));
                random_sent++;
            end
            phase++;
        end

        i_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);

        if (mismatch_count == 0 && pending_values.size() == 0)
            $display("polynomial_evaluator: match");
        else
            $display("polynomial_evaluator: mismatch");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("polynomial_evaluator: mismatch");
        $finish;
    end

endmodule
